// ===== rtl/core/ucdp_pkg.sv =====
// shared types and constants of the configuration descriptor parser
package ucdp_pkg;

  localparam int MaxInterfaces = 32;
  localparam int MaxEndpointsPerAlt = 32;
  localparam int MaxAltSettings = 128;
  localparam int QueueDepth = 4;
  localparam int QueueAw = $clog2(QueueDepth);

  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;
  localparam logic [7:0] DT_INTERFACE = 8'd4;
  localparam logic [7:0] DT_ENDPOINT = 8'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_IFACES = 3'd2;
  localparam logic [2:0] ST_ENDPOINTS = 3'd3;
  localparam logic [2:0] ST_ALTS = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FIRST,
    PH_INSIDE,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_SKIP,
    ROLE_ENDPOINT,
    ROLE_IFACE
  } role_t;

  // results caused by one byte
  typedef struct packed {
    logic        has_ep;
    logic [3:0]  ep_num;
    logic [15:0] mp_in;
    logic [15:0] mp_out;
    logic        has_sum;
    logic [2:0]  status;
    logic [7:0]  cfg_value;
    logic [5:0]  ifc_count;
  } rec_t;

endpackage

// ===== rtl/core/ucdp_front.sv =====
// byte parser: descriptor walk, packet tables and result records
module ucdp_front
  import ucdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data,
  input  logic       last,
  input  logic       cfg_valid,
  input  logic [6:0] cfg_data,
  output logic       push,
  output rec_t       rec
);

  phase_t      phase, phase_next;
  role_t       role, role_next;
  logic [7:0]  bid, bid_next;
  logic [7:0]  dlen, dlen_next;
  logic [7:0]  dtype, dtype_next;
  logic [31:0] fbuf, fbuf_next;
  logic [15:0] brem, brem_next;
  logic [5:0]  ifl, ifl_next;
  logic [5:0]  epl, epl_next;
  logic [7:0]  altc, altc_next;
  logic        alt0, alt0_next;
  logic [2:0]  err, err_next;
  logic [7:0]  cfgv, cfgv_next;
  logic [5:0]  decl, decl_next;
  logic        room, room_next;
  logic [6:0]  ep0;
  logic [15:0] in_tab [16];
  logic [15:0] out_tab [16];

  logic        start;
  logic        ep_wr;
  logic        ep_emit;
  logic [3:0]  ep_num;
  logic [15:0] new_in, new_out;
  logic [2:0]  sum_status;

  logic        stop;
  logic        go;
  logic [15:0] total;
  logic [15:0] mps;
  logic [15:0] oi, oo;
  logic [7:0]  alt, nep;

  always_comb begin
    phase_next = phase;
    role_next = role;
    bid_next = bid;
    dlen_next = dlen;
    dtype_next = dtype;
    fbuf_next = fbuf;
    brem_next = brem;
    ifl_next = ifl;
    epl_next = epl;
    altc_next = altc;
    alt0_next = alt0;
    err_next = err;
    cfgv_next = cfgv;
    decl_next = decl;
    room_next = room;
    start = 1'b0;
    ep_wr = 1'b0;
    ep_emit = 1'b0;
    ep_num = 4'd0;
    new_in = 16'd0;
    new_out = 16'd0;
    sum_status = ST_OK;
    stop = 1'b0;
    go = 1'b0;
    total = 16'd0;
    mps = 16'd0;
    oi = 16'd0;
    oo = 16'd0;
    alt = 8'd0;
    nep = 8'd0;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (bid == 8'd0) begin
            start = 1'b1;
            dtype_next = 8'd0;
            fbuf_next = 32'd0;
            brem_next = 16'd0;
            ifl_next = 6'd0;
            epl_next = 6'd0;
            altc_next = 8'd0;
            alt0_next = 1'b1;
            err_next = ST_OK;
            cfgv_next = 8'd0;
            decl_next = 6'd0;
            role_next = ROLE_SKIP;
            room_next = 1'b0;
            dlen_next = data;
            if (data < 8'd9) begin
              err_next = ST_BAD_LEN;
              phase_next = PH_ERROR;
              stop = 1'b1;
            end
          end else if (bid == 8'd2) begin
            fbuf_next = {24'd0, data};
          end else if (bid == 8'd3) begin
            total = {data, fbuf[7:0]};
            if (total < {8'd0, dlen}) begin
              if (err_next == ST_OK) err_next = ST_BAD_LEN;
              phase_next = PH_ERROR;
              stop = 1'b1;
            end else begin
              brem_next = total - 16'd4;
            end
          end else if (bid >= 8'd4) begin
            if (brem == 16'd0) begin
              if (err_next == ST_OK) err_next = ST_BAD_LEN;
              phase_next = PH_ERROR;
              stop = 1'b1;
            end else begin
              brem_next = brem - 16'd1;
              if (bid == 8'd4) begin
                if (data > 8'(MaxInterfaces)) begin
                  if (err_next == ST_OK) err_next = ST_IFACES;
                  phase_next = PH_ERROR;
                  stop = 1'b1;
                end else begin
                  decl_next = data[5:0];
                  ifl_next = data[5:0];
                end
              end else if (bid == 8'd5) begin
                cfgv_next = data;
              end
            end
          end
          if (!stop) begin
            if ({1'b0, bid} + 9'd1 == {1'b0, dlen_next}) begin
              bid_next = 8'd0;
              phase_next = (ifl_next != 6'd0) ? PH_FIRST : PH_DONE;
            end else begin
              bid_next = bid + 8'd1;
            end
          end
        end
        PH_FIRST, PH_INSIDE: begin
          if (brem == 16'd0) begin
            if (err_next == ST_OK) err_next = ST_BAD_LEN;
            phase_next = PH_ERROR;
          end else begin
            brem_next = brem - 16'd1;
            if (bid == 8'd0) begin
              if (data < 8'd2 || {8'd0, data} > brem) begin
                if (err_next == ST_OK) err_next = ST_BAD_LEN;
                phase_next = PH_ERROR;
              end else begin
                dlen_next = data;
                room_next = (brem >= 16'd9);
                fbuf_next = 32'd0;
                role_next = ROLE_SKIP;
                bid_next = 8'd1;
              end
            end else begin
              if (bid == 8'd1) begin
                dtype_next = data;
                if (!(data == DT_DEVICE || data == DT_CONFIG || data == DT_INTERFACE ||
                      data == DT_ENDPOINT)) begin
                  role_next = ROLE_SKIP;
                end else if (phase == PH_INSIDE && data == DT_ENDPOINT && epl != 6'd0) begin
                  role_next = ROLE_ENDPOINT;
                  epl_next = epl - 6'd1;
                end else begin
                  role_next = ROLE_IFACE;
                end
              end else if (bid == 8'd2) begin
                fbuf_next[7:0] = fbuf[7:0] | data;
              end else if (bid == 8'd3) begin
                fbuf_next[15:8] = fbuf[15:8] | data;
              end else if (bid == 8'd4) begin
                fbuf_next[23:16] = fbuf[23:16] | data;
              end else if (bid == 8'd5) begin
                fbuf_next[31:24] = fbuf[31:24] | data;
              end
              if (role_next == ROLE_ENDPOINT && bid == 8'd5 && alt0) begin
                ep_num = fbuf_next[3:0];
                mps = fbuf_next[31:16];
                oi = in_tab[ep_num];
                oo = out_tab[ep_num];
                new_in = oi;
                new_out = oo;
                if (fbuf_next[9:8] == 2'd0) begin
                  new_in = mps;
                  new_out = mps;
                end else if (!fbuf_next[7]) begin
                  if (mps > oo) new_out = mps;
                end else begin
                  if (mps > oi) new_in = mps;
                end
                ep_wr = 1'b1;
                ep_emit = (new_in != oi) || (new_out != oo);
              end
              if ({1'b0, bid} + 9'd1 == {1'b0, dlen}) begin
                bid_next = 8'd0;
                if (role_next == ROLE_IFACE) begin
                  alt = fbuf_next[15:8];
                  nep = fbuf_next[23:16];
                  if (phase == PH_INSIDE && dtype_next == DT_INTERFACE && alt != 8'd0 &&
                      room) begin
                    if (altc >= 8'(MaxAltSettings)) begin
                      if (err_next == ST_OK) err_next = ST_ALTS;
                      phase_next = PH_ERROR;
                    end else begin
                      altc_next = altc + 8'd1;
                      alt0_next = 1'b0;
                      go = 1'b1;
                    end
                  end else if (ifl == 6'd0) begin
                    phase_next = PH_DONE;
                  end else begin
                    ifl_next = ifl - 6'd1;
                    altc_next = 8'd1;
                    alt0_next = 1'b1;
                    go = 1'b1;
                  end
                  if (go) begin
                    if (nep > 8'(MaxEndpointsPerAlt)) begin
                      if (err_next == ST_OK) err_next = ST_ENDPOINTS;
                      phase_next = PH_ERROR;
                    end else begin
                      epl_next = nep[5:0];
                      phase_next = PH_INSIDE;
                    end
                  end
                end
              end else begin
                bid_next = bid + 8'd1;
              end
            end
          end
        end
        PH_DONE: begin
          if (brem == 16'd0) begin
            if (err_next == ST_OK) err_next = ST_BAD_LEN;
            phase_next = PH_ERROR;
          end else begin
            brem_next = brem - 16'd1;
          end
        end
        default: begin
        end
      endcase
      if (last) begin
        sum_status = err_next;
        if (sum_status == ST_OK && (phase_next == PH_HEADER || brem_next != 16'd0)) begin
          sum_status = ST_TRUNC;
        end
        phase_next = PH_HEADER;
        bid_next = 8'd0;
      end
    end
  end

  always_comb begin
    push = accept && (ep_emit || last);
    rec.has_ep = ep_emit;
    rec.ep_num = ep_num;
    rec.mp_in = new_in;
    rec.mp_out = new_out;
    rec.has_sum = last;
    rec.status = sum_status;
    rec.cfg_value = cfgv_next;
    rec.ifc_count = decl_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      role <= ROLE_SKIP;
      bid <= 8'd0;
      dlen <= 8'd0;
      dtype <= 8'd0;
      fbuf <= 32'd0;
      brem <= 16'd0;
      ifl <= 6'd0;
      epl <= 6'd0;
      altc <= 8'd0;
      alt0 <= 1'b1;
      err <= ST_OK;
      cfgv <= 8'd0;
      decl <= 6'd0;
      room <= 1'b0;
      ep0 <= 7'd8;
      for (int i = 1; i < 16; i++) begin
        in_tab[4'(i)] <= 16'd0;
        out_tab[4'(i)] <= 16'd0;
      end
      in_tab[0] <= 16'd8;
      out_tab[0] <= 16'd8;
    end else begin
      phase <= phase_next;
      role <= role_next;
      bid <= bid_next;
      dlen <= dlen_next;
      dtype <= dtype_next;
      fbuf <= fbuf_next;
      brem <= brem_next;
      ifl <= ifl_next;
      epl <= epl_next;
      altc <= altc_next;
      alt0 <= alt0_next;
      err <= err_next;
      cfgv <= cfgv_next;
      decl <= decl_next;
      room <= room_next;
      if (cfg_valid) ep0 <= cfg_data;
      if (start) begin
        for (int i = 1; i < 16; i++) begin
          in_tab[4'(i)] <= 16'd0;
          out_tab[4'(i)] <= 16'd0;
        end
        in_tab[0] <= {9'd0, ep0};
        out_tab[0] <= {9'd0, ep0};
      end else if (ep_wr) begin
        in_tab[ep_num] <= new_in;
        out_tab[ep_num] <= new_out;
      end
    end
  end

endmodule

// ===== rtl/core/ucdp_queue.sv =====
// small fifo of result records between parser and output stage
module ucdp_queue
  import ucdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wr_rec,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output rec_t rd_rec
);

  rec_t              mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr, rd_ptr;
  logic [QueueAw:0]   count;

  assign full = (count == (QueueAw + 1)'(QueueDepth));
  assign nonempty = (count != '0);
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_rec;
  end

endmodule

// ===== rtl/core/ucdp_back.sv =====
// output stage: splits records into result transactions
module ucdp_back
  import ucdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  rec_t        q_rec,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic        sel;
  logic        load;
  logic        take_ep;
  logic [3:0]  ep_num;
  logic [15:0] mp_in, mp_out;
  logic [2:0]  status;
  logic [7:0]  cfg_value;
  logic [5:0]  ifc_count;

  assign load = !m_tvalid || m_tready;
  assign take_ep = q_rec.has_ep && !sel;
  assign pop = load && q_valid && (!take_ep || !q_rec.has_sum);

  assign m_tdata = {3'd0, ifc_count, cfg_value, status, mp_out, mp_in, ep_num};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel <= 1'b0;
    end else if (load) begin
      m_tvalid <= q_valid;
      if (q_valid) sel <= take_ep && q_rec.has_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      if (take_ep) begin
        m_tuser <= KIND_UPDATE;
        ep_num <= q_rec.ep_num;
        mp_in <= q_rec.mp_in;
        mp_out <= q_rec.mp_out;
        status <= ST_OK;
        cfg_value <= 8'd0;
        ifc_count <= 6'd0;
        m_tlast <= !q_rec.has_sum;
      end else begin
        m_tuser <= KIND_SUMMARY;
        ep_num <= 4'd0;
        mp_in <= 16'd0;
        mp_out <= 16'd0;
        status <= q_rec.status;
        cfg_value <= q_rec.cfg_value;
        ifc_count <= q_rec.ifc_count;
        m_tlast <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/usb_config_descriptor_parser_unit.sv =====
// top level of the usb configuration descriptor parser
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: data_byte; tlast: last_byte
//  m_*       out  m_tvalid/m_tready    tdata: fields below; tlast: final_result; tuser: kind
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data: ep0_max_packet
//
//  one byte per cycle while s_tready is high; the parser updates all parse state in the accepting cycle
//  results leave through a four-record queue and an output register, one per cycle while m_tready is high
//  a byte causing an update and a summary yields two output transactions, the update first
//  s_tready drops only when the queue is full; cfg_ready is always high
//  rst is synchronous and restores the reset parser state and ep0 size of 8
module usb_config_descriptor_parser_unit
  import ucdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // endpoint_number, max_packet_in, max_packet_out, parse_status,
  // config_value, interface_count, zero fill
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser,   // kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic nonempty;
  rec_t wr_rec;
  rec_t rd_rec;

  assign s_tready = !full;
  assign accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  ucdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data      (s_tdata),
    .last      (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .rec       (wr_rec)
  );

  ucdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (wr_rec),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .rd_rec   (rd_rec)
  );

  ucdp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (nonempty),
    .q_rec    (rd_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== dv/tb_usb_config_descriptor_parser_unit.sv =====
// self-checking testbench of the usb configuration descriptor parser unit
module tb_usb_config_descriptor_parser_unit
  import ucdp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  ep_num;
    logic [15:0] mp_in;
    logic [15:0] mp_out;
    logic [2:0]  status;
    logic [7:0]  cfg_value;
    logic [5:0]  ifc_count;
    logic        final_res;
  } parse_result_t;

  localparam int CycleLimit = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  usb_config_descriptor_parser_unit DUT (.*);

  always #4 clk = ~clk;

  byte_item_t    pending_bytes[$];
  parse_result_t expected_results[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            bytes_sent = 0;
  bit            hold_sender = 1'b0;
  int            burst_left = 0;
  int            gap_left = 0;

  // predictor state
  logic [6:0]  p_ep0;
  phase_t      p_phase;
  logic [7:0]  p_k, p_len, p_type;
  logic [31:0] p_fields;
  logic [15:0] p_remaining;
  logic [5:0]  p_ifc_left, p_ep_left;
  logic [7:0]  p_alt_count;
  logic        p_alt_zero;
  logic [2:0]  p_err;
  logic [7:0]  p_cfg_value;
  logic [5:0]  p_declared;
  role_t       p_role;
  logic        p_room;
  logic [15:0] p_in_tab[16];
  logic [15:0] p_out_tab[16];

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic set_error(input logic [2:0] code);
    if (p_err == ST_OK) p_err = code;
    p_phase = PH_ERROR;
  endtask

  task automatic clear_bundle();
    for (int i = 0; i < 16; i++) begin
      p_in_tab[i] = '0;
      p_out_tab[i] = '0;
    end
    p_in_tab[0] = {9'd0, p_ep0};
    p_out_tab[0] = {9'd0, p_ep0};
    p_len = '0; p_type = '0; p_fields = '0; p_remaining = '0;
    p_ifc_left = '0; p_ep_left = '0; p_alt_count = '0; p_alt_zero = 1'b1;
    p_err = ST_OK; p_cfg_value = '0; p_declared = '0; p_role = ROLE_SKIP; p_room = 1'b0;
  endtask

  task automatic push_result(input logic kind, input logic [3:0] ep, input logic [15:0] pin,
                             input logic [15:0] pout, input logic [2:0] st,
                             input logic [7:0] cv, input logic [5:0] ic);
    parse_result_t r;
    r = '{kind, ep, pin, pout, st, cv, ic, 1'b0};
    expected_results.push_back(r);
  endtask

  task automatic apply_endpoint(ref int n);
    logic [7:0]  addr, attr;
    logic [15:0] mps, oi, oo;
    logic [3:0]  num;
    addr = p_fields[7:0];
    attr = p_fields[15:8];
    mps = p_fields[31:16];
    num = addr[3:0];
    oi = p_in_tab[num];
    oo = p_out_tab[num];
    if (attr[1:0] == 2'd0) begin
      p_in_tab[num] = mps;
      p_out_tab[num] = mps;
    end else if (!addr[7]) begin
      if (mps > oo) p_out_tab[num] = mps;
    end else begin
      if (mps > oi) p_in_tab[num] = mps;
    end
    if (p_in_tab[num] != oi || p_out_tab[num] != oo) begin
      push_result(KIND_UPDATE, num, p_in_tab[num], p_out_tab[num], ST_OK, 8'd0, 6'd0);
      n++;
    end
  endtask

  task automatic finish_interface();
    logic [7:0] alt, num_ep;
    alt = p_fields[15:8];
    num_ep = p_fields[23:16];
    if (p_phase == PH_INSIDE && p_type == DT_INTERFACE && alt != 0 && p_room) begin
      if (p_alt_count >= MaxAltSettings) begin
        set_error(ST_ALTS);
        return;
      end
      p_alt_count++;
      p_alt_zero = 1'b0;
    end else begin
      if (p_ifc_left == 0) begin
        p_phase = PH_DONE;
        return;
      end
      p_ifc_left--;
      p_alt_count = 8'd1;
      p_alt_zero = 1'b1;
    end
    if (num_ep > MaxEndpointsPerAlt) begin
      set_error(ST_ENDPOINTS);
      return;
    end
    p_ep_left = num_ep[5:0];
    p_phase = PH_INSIDE;
  endtask

  task automatic body_byte(input logic [7:0] b, ref int n);
    logic [15:0] rem;
    logic [7:0]  k;
    rem = p_remaining;
    k = p_k;
    if (rem == 0) begin
      set_error(ST_BAD_LEN);
      return;
    end
    p_remaining--;
    if (k == 0) begin
      if (b < 2 || 16'(b) > rem) begin
        set_error(ST_BAD_LEN);
        return;
      end
      p_len = b;
      p_room = rem >= 9;
      p_fields = '0;
      p_role = ROLE_SKIP;
      p_k = 8'd1;
      return;
    end
    if (k == 1) begin
      p_type = b;
      if (!(b == DT_DEVICE || b == DT_CONFIG || b == DT_INTERFACE || b == DT_ENDPOINT))
        p_role = ROLE_SKIP;
      else if (p_phase == PH_INSIDE && b == DT_ENDPOINT && p_ep_left > 0) begin
        p_role = ROLE_ENDPOINT;
        p_ep_left--;
      end else
        p_role = ROLE_IFACE;
    end else if (k >= 2 && k <= 5) begin
      p_fields |= 32'(b) << (8 * (k - 2));
    end
    if (p_role == ROLE_ENDPOINT && k == 5 && p_alt_zero) apply_endpoint(n);
    if (9'(k) + 9'd1 == 9'(p_len)) begin
      p_k = '0;
      if (p_role == ROLE_IFACE) finish_interface();
    end else
      p_k++;
  endtask

  task automatic header_byte(input logic [7:0] b);
    logic [7:0]  k;
    logic [15:0] total;
    k = p_k;
    if (k == 0) begin
      clear_bundle();
      p_len = b;
      if (b < 9) begin
        set_error(ST_BAD_LEN);
        return;
      end
    end else if (k == 2) begin
      p_fields = 32'(b);
    end else if (k == 3) begin
      total = {b, p_fields[7:0]};
      if (total < 16'(p_len)) begin
        set_error(ST_BAD_LEN);
        return;
      end
      p_remaining = total - 16'd4;
    end else if (k >= 4) begin
      if (p_remaining == 0) begin
        set_error(ST_BAD_LEN);
        return;
      end
      p_remaining--;
      if (k == 4) begin
        if (b > MaxInterfaces) begin
          set_error(ST_IFACES);
          return;
        end
        p_declared = b[5:0];
        p_ifc_left = b[5:0];
      end else if (k == 5)
        p_cfg_value = b;
    end
    if (9'(k) + 9'd1 == 9'(p_len)) begin
      p_k = '0;
      p_phase = (p_ifc_left != 0) ? PH_FIRST : PH_DONE;
    end else
      p_k++;
  endtask

  task automatic predict_byte(input byte_item_t it);
    int n;
    logic [2:0] st;
    n = 0;
    case (p_phase)
      PH_HEADER: header_byte(it.data);
      PH_FIRST, PH_INSIDE: body_byte(it.data, n);
      PH_DONE: begin
        if (p_remaining == 0) set_error(ST_BAD_LEN);
        else p_remaining--;
      end
      default: ;
    endcase
    if (it.last) begin
      st = p_err;
      if (st == ST_OK && (p_phase == PH_HEADER || p_remaining != 0)) st = ST_TRUNC;
      push_result(KIND_SUMMARY, 4'd0, 16'd0, 16'd0, st, p_cfg_value, p_declared);
      n++;
      p_phase = PH_HEADER;
      p_k = '0;
    end
    if (n > 0) expected_results[$].final_res = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_byte('{s_tlast, s_tdata});
        bytes_sent <= bytes_sent + 1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0 && !hold_sender) begin
          byte_item_t nx;
          nx = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nx.data;
          s_tlast <= nx.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else
            burst_left <= burst_left - 1;
        end else
          s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= (cycle_count % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (m_tvalid && m_tready) begin
        parse_result_t got, exp_r;
        got = '{m_tuser, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tdata[38:36],
                m_tdata[46:39], m_tdata[52:47], m_tlast};
        if (expected_results.size() == 0)
          report("result with nothing expected");
        else begin
          exp_r = expected_results.pop_front();
          if (got.kind != exp_r.kind) report("kind");
          if (got.ep_num != exp_r.ep_num) report("endpoint number");
          if (got.mp_in != exp_r.mp_in) report("max packet in");
          if (got.mp_out != exp_r.mp_out) report("max packet out");
          if (got.status != exp_r.status) report("parse status");
          if (got.cfg_value != exp_r.cfg_value) report("config value");
          if (got.ifc_count != exp_r.ifc_count) report("interface count");
          if (got.final_res != exp_r.final_res) report("final result flag");
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("usb_config_descriptor_parser_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
    pending_bytes.push_back('{last, b});
  endtask

  // well-formed bundle with random content and occasional damage
  task automatic add_bundle(input bit damage);
    logic [7:0] body[$];
    int n_if, n_alt, n_ep, total, hl, cut;
    byte_item_t q[$];
    n_if = $urandom_range(0, 3);
    for (int i = 0; i < n_if; i++) begin
      n_alt = ($urandom_range(0, 3) == 0) ? 1 : 0;
      for (int a = 0; a <= n_alt; a++) begin
        n_ep = $urandom_range(0, 3);
        body.push_back(8'd9); body.push_back(DT_INTERFACE); body.push_back(8'(i));
        body.push_back(8'(a)); body.push_back(8'(n_ep));
        repeat (4) body.push_back(rnd_byte());
        if ($urandom_range(0, 4) == 0) begin
          body.push_back(8'd4); body.push_back(8'h24); body.push_back(rnd_byte());
          body.push_back(rnd_byte());
        end
        for (int e = 0; e < n_ep; e++) begin
          body.push_back(8'd7); body.push_back(DT_ENDPOINT);
          body.push_back({$urandom_range(0, 1) == 1, 3'd0, 4'($urandom_range(0, 15))});
          body.push_back(8'($urandom_range(0, 3)));
          body.push_back(rnd_byte());
          body.push_back(8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 4)));
          body.push_back(rnd_byte());
        end
      end
    end
    hl = 9;
    total = hl + body.size();
    q.push_back('{1'b0, 8'(hl)});
    q.push_back('{1'b0, DT_CONFIG});
    q.push_back('{1'b0, total[7:0]});
    q.push_back('{1'b0, total[15:8]});
    q.push_back('{1'b0, 8'(n_if)});
    q.push_back('{1'b0, rnd_byte()});
    repeat (3) q.push_back('{1'b0, rnd_byte()});
    foreach (body[i]) q.push_back('{1'b0, body[i]});
    if (damage) begin
      cut = $urandom_range(0, 3);
      if (cut == 0 && q.size() > 2) q = q[0:$urandom_range(0, q.size() - 2)];
      else if (cut == 1) q.push_back('{1'b0, rnd_byte()});
      else q[$urandom_range(0, q.size() - 1)].data = rnd_byte();
    end
    q[$].last = 1'b1;
    foreach (q[i]) pending_bytes.push_back(q[i]);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ep0(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_ep0 = v;
  endtask

  initial begin
    logic [6:0] ep0_choices[4];
    ep0_choices = '{7'd8, 7'd64, 7'd127, 7'd0};
    p_ep0 = 7'd8;
    clear_bundle();
    p_phase = PH_HEADER;
    p_k = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short header, short total, too many interfaces, truncation, empty configuration
    add_byte(8'd3, 1'b1);
    add_byte(8'd9); add_byte(DT_CONFIG); add_byte(8'd4); add_byte(8'd0, 1'b1);
    add_byte(8'd9); add_byte(DT_CONFIG); add_byte(8'd9); add_byte(8'd0);
    add_byte(8'd33); add_byte(8'hff, 1'b1);
    add_byte(8'd9); add_byte(DT_CONFIG); add_byte(8'd30); add_byte(8'd0, 1'b1);
    add_byte(8'hff); add_byte(8'hff, 1'b1);
    add_byte(8'd9); add_byte(DT_CONFIG); add_byte(8'd9); add_byte(8'd0);
    add_byte(8'd0); add_byte(8'hff); add_byte(8'h00); add_byte(8'hff); add_byte(8'h55, 1'b1);
    add_bundle(1'b0);
    wait_drained();

    foreach (ep0_choices[c]) begin
      write_ep0(ep0_choices[c]);
      while (bytes_sent < 360 * (c + 1)) begin
        if (pending_bytes.size() < 50) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) add_byte(rnd_byte(), $urandom_range(0, 7) == 0);
            add_byte(rnd_byte(), 1'b1);
          end else
            add_bundle($urandom_range(0, 3) == 0);
        end
        if (c == 1 && bytes_sent > 500 && bytes_sent < 520) begin
          hold_sender = 1'b1;
          while (s_tvalid || expected_results.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
        @(posedge clk);
      end
      wait_drained();
    end

    if (error_count == 0)
      $display("usb_config_descriptor_parser_unit regression: pass");
    else
      $display("usb_config_descriptor_parser_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ucdp_pkg.sv
rtl/core/ucdp_front.sv
rtl/core/ucdp_queue.sv
rtl/core/ucdp_back.sv
rtl/core/usb_config_descriptor_parser_unit.sv
dv/tb_usb_config_descriptor_parser_unit.sv
